[rtl/core/cfc_pkg.sv]
`timescale 1ns / 1ps

package cfc_pkg;

   localparam int CFC_MAX_COUNT = 255;

   localparam logic [7:0]  MAGIC_RESET   = 8'hA5;
   localparam logic [7:0]  VERSION_RESET = 8'h01;
   localparam logic [7:0]  MSG_CMD       = 8'h01;
   localparam logic [15:0] PAYLOAD_LEN   = 16'd4;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   // Register map of the configuration port.
   typedef enum logic [0:0] {
      CSR_MAGIC   = 1'b0,
      CSR_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_SHORT   = 3'd1,
      ERR_MAGIC   = 3'd2,
      ERR_TYPELEN = 3'd3,
      ERR_TOTLEN  = 3'd4,
      ERR_CRC     = 3'd5
   } err_code_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic         frame_ok;
      err_code_type error_code;
      logic [7:0]   channel;
      logic [15:0]  frame_seq;
      logic [15:0]  brightness;
      logic [7:0]   lamp_state;
      logic [7:0]   telemetry_request;
   } rsp_payload_type;

   // One byte of CRC-16/CCITT-FALSE, MSB first, no reflection.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/core/command_frame_checker_unit.sv]
`timescale 1ns / 1ps

// Command frame checker.
//
// Frame bytes enter one beat at a time on the req_ channel; end_of_frame marks
// the last byte. A frame is a 10-byte header (magic, version, type, channel,
// then little-endian length, sequence and crc) followed by a 4-byte command
// payload. For every last byte one result beat leaves on the rsp_ channel with
// the error code, the header channel and sequence, and the payload fields.
//
// Throughput is one byte per cycle while no result beat is stalled: the bytewise
// CRC update and the final checks sit between the frame state registers and
// the result register. rsp_valid rises in the cycle after the last byte is
// accepted. Bytes that are not last produce no result beat.
//
// The csr_ port writes the expected magic and version; write it only while the
// block is idle. Reset restores both registers, clears the frame state and
// drops rsp_valid. When the receiver stalls, the result is held in the output
// register and req_ready stays low until that beat is taken, except in the
// cycle in which it is taken.

module command_frame_checker_unit
   import cfc_pkg::*;
#(
   parameter int MAX_COUNT = CFC_MAX_COUNT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  csr_index_type   csr_index,
   input  logic [7:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_COUNT + 1);

   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_COUNT);
   localparam logic [CNT_W-1:0] CNT_HDR   = CNT_W'(10);
   localparam logic [CNT_W-1:0] CNT_FRAME = CNT_W'(14);

   // Configuration registers.
   logic [7:0] magic_cfg_ff;
   logic [7:0] version_cfg_ff;

   // Frame state.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      run_crc_ff, run_crc_in;
   logic [15:0]      hdr_crc_ff, hdr_crc_in;
   logic [7:0]       magic_ff, magic_in;
   logic [7:0]       version_ff, version_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       channel_ff, channel_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      seq_ff, seq_in;
   logic [15:0]      rx_crc_ff, rx_crc_in;
   logic [31:0]      payload_ff, payload_in;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic        in_frame;
   logic [3:0]  pos;
   logic [7:0]  b;
   logic [7:0]  crc_data;
   logic [15:0] crc_step;
   err_code_type err;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b        = req_data.rx_byte;
   assign in_frame = count_ff < CNT_FRAME;
   assign pos      = count_ff[3:0];

   // Header crc bytes enter the CRC as zero.
   assign crc_data = (pos == 4'd8 || pos == 4'd9) ? 8'h00 : b;
   assign crc_step = crc16_byte(run_crc_ff, crc_data);

   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      type_in    = type_ff;
      channel_in = channel_ff;
      len_in     = len_ff;
      seq_in     = seq_ff;
      rx_crc_in  = rx_crc_ff;
      payload_in = payload_ff;
      hdr_crc_in = hdr_crc_ff;
      run_crc_in = run_crc_ff;
      if (in_frame) begin
         run_crc_in = crc_step;
         case (pos)
            4'd0:    magic_in            = b;
            4'd1:    version_in          = b;
            4'd2:    type_in             = b;
            4'd3:    channel_in          = b;
            4'd4:    len_in[7:0]         = b;
            4'd5:    len_in[15:8]        = b;
            4'd6:    seq_in[7:0]         = b;
            4'd7:    seq_in[15:8]        = b;
            4'd8:    rx_crc_in[7:0]      = b;
            4'd9: begin
               rx_crc_in[15:8] = b;
               // Header CRC is complete; the payload CRC starts afresh.
               hdr_crc_in      = crc_step;
               run_crc_in      = CRC_INIT;
            end
            4'd10:   payload_in[7:0]     = b;
            4'd11:   payload_in[15:8]    = b;
            4'd12:   payload_in[23:16]   = b;
            4'd13:   payload_in[31:24]   = b;
            default: ;
         endcase
      end
      count_in = (count_ff < CNT_MAX) ? count_ff + CNT_W'(1) : count_ff;
   end

   // Checks in priority order, on the state as it stands after this byte.
   always_comb begin
      if (count_in < CNT_HDR) begin
         err = ERR_SHORT;
      end else if (magic_in != magic_cfg_ff || version_in != version_cfg_ff) begin
         err = ERR_MAGIC;
      end else if (type_in != MSG_CMD || len_in != PAYLOAD_LEN) begin
         err = ERR_TYPELEN;
      end else if (count_in != CNT_FRAME) begin
         err = ERR_TOTLEN;
      end else if ((hdr_crc_in ^ run_crc_in) != rx_crc_in) begin
         err = ERR_CRC;
      end else begin
         err = ERR_NONE;
      end

      rsp_data_in                   = '0;
      rsp_data_in.error_code        = err;
      rsp_data_in.frame_ok          = (err == ERR_NONE);
      if (err != ERR_SHORT) begin
         rsp_data_in.channel   = channel_in;
         rsp_data_in.frame_seq = seq_in;
      end
      if (err == ERR_NONE) begin
         rsp_data_in.brightness        = payload_in[15:0];
         rsp_data_in.lamp_state        = payload_in[23:16];
         rsp_data_in.telemetry_request = payload_in[31:24];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_cfg_ff   <= MAGIC_RESET;
         version_cfg_ff <= VERSION_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC:   magic_cfg_ff   <= csr_wdata;
            CSR_VERSION: version_cfg_ff <= csr_wdata;
         endcase
      end
   end

   // The frame state returns to its reset value after each last byte.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.end_of_frame)) begin
         count_ff   <= '0;
         run_crc_ff <= CRC_INIT;
         hdr_crc_ff <= '0;
         magic_ff   <= '0;
         version_ff <= '0;
         type_ff    <= '0;
         channel_ff <= '0;
         len_ff     <= '0;
         seq_ff     <= '0;
         rx_crc_ff  <= '0;
         payload_ff <= '0;
      end else if (accept) begin
         count_ff   <= count_in;
         run_crc_ff <= run_crc_in;
         hdr_crc_ff <= hdr_crc_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         type_ff    <= type_in;
         channel_ff <= channel_in;
         len_ff     <= len_in;
         seq_ff     <= seq_in;
         rx_crc_ff  <= rx_crc_in;
         payload_ff <= payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_data.end_of_frame) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.end_of_frame) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[rtl/core/cfc_checker.sv]
`timescale 1ns / 1ps

module cfc_checker
   import cfc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A stalled result beat keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // A new result beat follows only the acceptance of a last byte.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.end_of_frame))
      else $error("result beat without a last byte");

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.frame_ok == (rsp_data.error_code == ERR_NONE))
      else $error("frame_ok disagrees with error_code");

   // A failed frame never leaks payload fields.
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code != ERR_NONE |->
         rsp_data.brightness == 16'd0 && rsp_data.lamp_state == 8'd0 &&
         rsp_data.telemetry_request == 8'd0)
      else $error("payload fields set on a failed frame");

endmodule

bind command_frame_checker_unit cfc_checker u_cfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/cfc_frame_monitor.sv]
`timescale 1ns / 1ps

package frame_crc_pkg;

   // CRC-16/CCITT-FALSE over one byte, shifting one data bit in per step.
   function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      logic        feedback;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = acc[15] ^ data[i];
         acc      = {acc[14:0], 1'b0};
         if (feedback) begin
            acc = acc ^ cfc_pkg::CRC_POLY;
         end
      end
      return acc;
   endfunction

endpackage

// Watches both channels and the register port, predicts the verdict of every
// frame and compares each result beat against the oldest pending verdict.
module cfc_frame_monitor
   import cfc_pkg::*;
   import frame_crc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  csr_index_type   csr_index,
   input  logic [7:0]      csr_wdata,
   output int              error_count,
   output int              pending_beats
);

   localparam int unsigned HEADER_BEATS = 10;
   localparam int unsigned CRC_FIRST    = 8;
   localparam int unsigned FRAME_BEATS  = 14;

   logic [7:0]      magic_cfg   = MAGIC_RESET;
   logic [7:0]      version_cfg = VERSION_RESET;
   int unsigned     beat_count;
   logic [15:0]     crc_acc;
   logic [15:0]     header_crc;
   logic [15:0]     sent_crc;
   logic [63:0]     header_bytes;
   logic [31:0]     payload_bytes;
   rsp_payload_type expected_verdicts[$];
   int              mismatches = 0;

   task automatic clear_frame();
      beat_count    = 0;
      crc_acc       = CRC_INIT;
      header_crc    = '0;
      sent_crc      = '0;
      header_bytes  = '0;
      payload_bytes = '0;
   endtask

   function automatic rsp_payload_type judge_frame();
      rsp_payload_type v;
      v = '0;
      if (beat_count < HEADER_BEATS) begin
         v.error_code = ERR_SHORT;
      end else begin
         // The header fields are reported even when a later check fails.
         v.channel   = header_bytes[31:24];
         v.frame_seq = header_bytes[63:48];
         if (header_bytes[7:0] != magic_cfg || header_bytes[15:8] != version_cfg) begin
            v.error_code = ERR_MAGIC;
         end else if (header_bytes[23:16] != MSG_CMD || header_bytes[47:32] != PAYLOAD_LEN) begin
            v.error_code = ERR_TYPELEN;
         end else if (beat_count != FRAME_BEATS) begin
            v.error_code = ERR_TOTLEN;
         end else if ((header_crc ^ crc_acc) != sent_crc) begin
            v.error_code = ERR_CRC;
         end else begin
            v.error_code        = ERR_NONE;
            v.frame_ok          = 1'b1;
            v.brightness        = payload_bytes[15:0];
            v.lamp_state        = payload_bytes[23:16];
            v.telemetry_request = payload_bytes[31:24];
         end
      end
      return v;
   endfunction

   task automatic take_byte(input logic [7:0] value, input logic last);
      if (beat_count < CRC_FIRST) begin
         header_bytes[8 * beat_count +: 8] = value;
         crc_acc = ccitt_next(crc_acc, value);
      end else if (beat_count < HEADER_BEATS) begin
         // The crc bytes enter the header CRC as zero.
         sent_crc[8 * (beat_count - CRC_FIRST) +: 8] = value;
         crc_acc = ccitt_next(crc_acc, 8'h00);
         if (beat_count == HEADER_BEATS - 1) begin
            header_crc = crc_acc;
            crc_acc    = CRC_INIT;
         end
      end else if (beat_count < FRAME_BEATS) begin
         payload_bytes[8 * (beat_count - HEADER_BEATS) +: 8] = value;
         crc_acc = ccitt_next(crc_acc, value);
      end
      if (beat_count < CFC_MAX_COUNT) begin
         beat_count++;
      end
      if (last) begin
         expected_verdicts.push_back(judge_frame());
         clear_frame();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result field %s is 0x%0h, predicted 0x%0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_payload_type want;
      if (reset) begin
         magic_cfg   = MAGIC_RESET;
         version_cfg = VERSION_RESET;
         clear_frame();
         expected_verdicts.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result beat with no frame awaiting a verdict");
            end else begin
               want = expected_verdicts.pop_front();
               check_field("frame_ok", rsp_data.frame_ok, want.frame_ok);
               check_field("error_code", rsp_data.error_code, want.error_code);
               check_field("channel", rsp_data.channel, want.channel);
               check_field("frame_seq", rsp_data.frame_seq, want.frame_seq);
               check_field("brightness", rsp_data.brightness, want.brightness);
               check_field("lamp_state", rsp_data.lamp_state, want.lamp_state);
               check_field("telemetry_request", rsp_data.telemetry_request,
                           want.telemetry_request);
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MAGIC: begin
                  magic_cfg = csr_wdata;
               end
               CSR_VERSION: begin
                  version_cfg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            take_byte(req_data.rx_byte, req_data.end_of_frame);
         end
      end
      error_count   <= mismatches;
      pending_beats <= expected_verdicts.size();
   end

endmodule

[tb/tb_command_frame_checker_unit.sv]
`timescale 1ns / 1ps

// Top of the frame checker bench. It builds frames, pushes them into the block
// one byte per beat, shapes the result channel's backpressure and writes the
// magic and version registers between phases. All prediction and comparison
// happens in the monitor; this module only decides the verdict at the end.
module tb_command_frame_checker_unit;
   import cfc_pkg::*;
   import frame_crc_pkg::*;

   // Bytes of random frames per register setting. Six settings give close to
   // two thousand beats, the saturating frame included.
   localparam int PHASE_BYTES  = 320;
   // Margin after the last verdict has come back.
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_COUNT  = 6;

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_data    = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_we      = 1'b0;
   csr_index_type   csr_index   = CSR_MAGIC;
   logic [7:0]      csr_wdata   = '0;
   int              error_count;
   int              pending_beats;

   // Frame under construction and the register values frames are built for.
   logic [7:0] frame_bytes[$];
   logic [7:0] magic_now   = MAGIC_RESET;
   logic [7:0] version_now = VERSION_RESET;
   int         burst_left  = 0;
   int         phase_bytes = 0;
   int         ready_mode  = 0;
   int         ready_hold  = 0;

   command_frame_checker_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cfc_frame_monitor frame_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_beats (pending_beats)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver switches between stall patterns at random intervals: always
   // ready, coin flips, mostly stalled, and a fixed duty cycle. Since the block
   // holds req_ready low while a result waits, these stalls also hold back the
   // byte that follows the last byte of a frame.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_hold <= $urandom_range(50, 300);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ((ready_hold % 7) < 3);
         end
      endcase
   end

   // Builds a well-formed command frame for the current magic and version.
   // The crc field is the header CRC (crc bytes taken as zero) XOR the
   // payload CRC, both started from the CCITT-FALSE initial value.
   function automatic void build_command(input logic [7:0] chan, input logic [15:0] seq,
                                         input logic [15:0] bright, input logic [7:0] lamp,
                                         input logic [7:0] telem);
      logic [111:0] frame;
      logic [15:0]  head_crc;
      logic [15:0]  body_crc;
      frame = {telem, lamp, bright, 16'h0000, seq, PAYLOAD_LEN, chan, MSG_CMD,
               version_now, magic_now};
      head_crc = CRC_INIT;
      body_crc = CRC_INIT;
      for (int i = 0; i < 10; i++) begin
         head_crc = ccitt_next(head_crc, (i < 8) ? frame[8 * i +: 8] : 8'h00);
      end
      for (int i = 10; i < 14; i++) begin
         body_crc = ccitt_next(body_crc, frame[8 * i +: 8]);
      end
      frame[79:64] = head_crc ^ body_crc;
      frame_bytes.delete();
      for (int i = 0; i < 14; i++) begin
         frame_bytes.push_back(frame[8 * i +: 8]);
      end
   endfunction

   // Offers one byte. Between bursts the sender drops valid for a random gap;
   // now and then a long burst gives a stretch with no idling at all. Valid is
   // only lowered at the start of a gap, never between back-to-back beats.
   task automatic send_beat(input logic [7:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= {value, last};
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Sends the staged bytes; only the final byte carries end_of_frame.
   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      phase_bytes += frame_bytes.size();
   endtask

   // Mostly good frames with random content, so that the CRC and length
   // checks are reached; the rest hit each error path in turn.
   task automatic send_random_frame();
      int kind;
      int pos;
      int keep;
      kind = $urandom_range(0, 99);
      build_command(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      if (kind < 60) begin
         // Good frame as built.
      end else if (kind < 70) begin
         // Flip bits in one header byte: magic, version, type, length or crc
         // errors, or a CRC error when channel or sequence are hit.
         pos = $urandom_range(0, 9);
         frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end else if (kind < 75) begin
         // A damaged payload byte is caught only by the CRC.
         pos = $urandom_range(10, 13);
         frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
      end else if (kind < 80) begin
         frame_bytes[$urandom_range(0, 1)] = 8'($urandom);
      end else if (kind < 87) begin
         // Short frame: ends before the header is complete.
         keep = $urandom_range(1, 9);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end else if (kind < 93) begin
         // Full header but a truncated payload.
         keep = $urandom_range(10, 13);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end else if (kind < 98) begin
         // Long frame: trailing bytes are counted but not stored.
         repeat ($urandom_range(1, 10)) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
      end
      send_frame();
   endtask

   // Stops the stream and waits until every verdict has come back. The first
   // edge lets the monitor register the final frame before its count is read.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers on consecutive edges, with the enable held high across them.
   task automatic write_regs(input logic [7:0] magic, input logic [7:0] version);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAGIC;
      csr_wdata <= magic;
      @(posedge clock);
      csr_index <= CSR_VERSION;
      csr_wdata <= version;
      @(posedge clock);
      csr_we      <= 1'b0;
      magic_now   = magic;
      version_now = version;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values: a good frame with
      // extreme field values, a frame of a single byte, and a frame that ends
      // right after its header.
      build_command(8'hFF, 16'h0000, 16'hFFFF, 8'h00, 8'hFF);
      send_frame();
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      send_frame();
      build_command(8'h00, 16'hFFFF, 16'h0000, 8'hFF, 8'h00);
      while (frame_bytes.size() > 10) void'(frame_bytes.pop_back());
      send_frame();
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_regs(8'h00, 8'h00);
            end
            1: begin
               write_regs(8'hFF, 8'hFF);
            end
            2: begin
               write_regs(MAGIC_RESET, VERSION_RESET);
            end
            default: begin
               write_regs(8'($urandom), 8'($urandom));
            end
         endcase
         phase_bytes = 0;
         if (phase == 0) begin
            // One frame long enough for the byte count to saturate.
            build_command(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
                          8'($urandom));
            repeat ($urandom_range(242, 250)) frame_bytes.push_back(8'($urandom));
            send_frame();
         end
         while (phase_bytes < PHASE_BYTES) begin
            send_random_frame();
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Far beyond the slowest legal run: a hang or a verdict that never comes
   // ends here.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
rtl/core/cfc_pkg.sv
rtl/core/command_frame_checker_unit.sv
rtl/core/cfc_checker.sv
tb/cfc_frame_monitor.sv
tb/tb_command_frame_checker_unit.sv
